// ----- rtl/core/arm64_unwind_code_decoder_unit_macros.svh -----
// Assertion macros for the unwind code decoder.
// Used by the top level; no other dependency. Bodies vanish under SYNTHESIS.
`ifndef ARM64_UNWIND_CODE_DECODER_UNIT_MACROS_SVH
`define ARM64_UNWIND_CODE_DECODER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define AUCD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("aucd: same-cycle check failed");
// next-cycle implication
`define AUCD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("aucd: next-cycle check failed");
`else
`define AUCD_ASSERT_IMP(label, clk, rst, ante, cons)
`define AUCD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/core/aucd_pkg.sv -----
// Shared types and constants for the unwind code decoder.
// No dependencies; used by arm64_unwind_code_decoder_unit.
package aucd_pkg;

   localparam logic [9:0] MaxRegionOps = 10'd1020;

   // first bytes with a fixed meaning
   localparam logic [7:0] CodeAllocL    = 8'hE0;
   localparam logic [7:0] CodeSetFp     = 8'hE1;
   localparam logic [7:0] CodeAddFp     = 8'hE2;
   localparam logic [7:0] CodeEnd       = 8'hE4;
   localparam logic [7:0] CodeEndC      = 8'hE5;
   localparam logic [7:0] CodeSaveNext  = 8'hE6;
   localparam logic [7:0] CodePacSignLr = 8'hFC;

   typedef enum logic [4:0] {
      OP_ALLOC_S       = 5'd0,
      OP_SAVE_R19R20_X = 5'd1,
      OP_SAVE_FPLR     = 5'd2,
      OP_SAVE_FPLR_X   = 5'd3,
      OP_ALLOC_M       = 5'd4,
      OP_SAVE_REGP     = 5'd5,
      OP_SAVE_REGP_X   = 5'd6,
      OP_SAVE_REG      = 5'd7,
      OP_SAVE_REG_X    = 5'd8,
      OP_SAVE_LRPAIR   = 5'd9,
      OP_SAVE_FREGP    = 5'd10,
      OP_SAVE_FREGP_X  = 5'd11,
      OP_SAVE_FREG     = 5'd12,
      OP_SAVE_FREG_X   = 5'd13,
      OP_ALLOC_L       = 5'd14,
      OP_SET_FP        = 5'd15,
      OP_ADD_FP        = 5'd16,
      OP_NOP           = 5'd17,
      OP_END           = 5'd18,
      OP_END_C         = 5'd19,
      OP_SAVE_NEXT     = 5'd20,
      OP_PAC_SIGN_LR   = 5'd21
   } op_kind_type;

   typedef struct packed {
      logic [7:0] code_byte;
      logic       region_last;
   } req_beat_type;

   typedef struct packed {
      logic [4:0]  op_type;
      logic [4:0]  reg_number;
      logic [27:0] byte_operand;
      logic [9:0]  op_index;
      logic        is_truncated;
   } rsp_beat_type;

endpackage

// ----- rtl/core/arm64_unwind_code_decoder_unit.sv -----
// Unwind code decoder: one code byte per beat in, one decoded operation out per code.
// A beat waits in the input register; the result of a completed code is registered.
// One byte per cycle unless rsp_stall holds a result; input register, decode logic, result register.
// Reset clears the byte position, operation counter, skip flag and both valid bits;
// the gathered code bytes are left as they are.
`include "arm64_unwind_code_decoder_unit_macros.svh"

module arm64_unwind_code_decoder_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  aucd_pkg::req_beat_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output aucd_pkg::rsp_beat_type rsp_data
);

   logic                   s1_valid_ff, s1_valid_in;
   aucd_pkg::req_beat_type s1_data_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   aucd_pkg::rsp_beat_type rsp_data_ff, rsp_data_in;
   logic [2:0]             pos_ff, pos_in;
   logic [9:0]             cnt_ff, cnt_in;
   logic                   skip_ff, skip_in;
   logic [7:0]             gath_ff [4];

   logic        req_take;
   logic        advance;
   logic [7:0]  cb;
   logic [7:0]  byte_a, byte_b, byte_c, byte_d;
   logic [2:0]  code_len;
   logic [2:0]  pos_plus;
   logic        complete;
   logic        emit;
   logic        end_seen;
   logic [4:0]  dec_type;
   logic [5:0]  dec_reg_wide;
   logic [4:0]  dec_reg;
   logic [27:0] dec_opnd;
   logic [27:0] off6, off6p, off5p;

   // Move the held beat into decode when the result slot is free or draining.
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign cb        = s1_data_ff.code_byte;

   // Bytes of the current code, with this beat's byte in its slot.
   assign byte_a = (pos_ff == 3'd0) ? cb : gath_ff[0];
   assign byte_b = (pos_ff == 3'd1) ? cb : gath_ff[1];
   assign byte_c = (pos_ff == 3'd2) ? cb : gath_ff[2];
   assign byte_d = (pos_ff == 3'd3) ? cb : gath_ff[3];

   always_comb begin
      case (byte_a) inside
         [8'h00:8'hBF]: code_len = 3'd1;
         [8'hC0:8'hDF]: code_len = 3'd2;
         8'hE0:         code_len = 3'd4;
         8'hE2:         code_len = 3'd2;
         8'hE7:         code_len = 3'd3;
         8'hF8:         code_len = 3'd2;
         8'hF9:         code_len = 3'd3;
         8'hFA:         code_len = 3'd4;
         8'hFB:         code_len = 3'd5;
         default:       code_len = 3'd1;
      endcase
   end

   assign pos_plus = pos_ff + 3'd1;
   assign complete = pos_plus >= code_len;

   assign off6  = {19'd0, byte_b[5:0], 3'd0};
   assign off6p = {18'd0, ({1'b0, byte_b[5:0]} + 7'd1), 3'd0};
   assign off5p = {19'd0, ({1'b0, byte_b[4:0]} + 6'd1), 3'd0};

   always_comb begin
      dec_type     = aucd_pkg::OP_NOP;
      dec_reg_wide = 6'd0;
      dec_opnd     = 28'd0;
      case (byte_a) inside
         [8'h00:8'h1F]: begin
            dec_type = aucd_pkg::OP_ALLOC_S;
            dec_opnd = {19'd0, byte_a[4:0], 4'd0};
         end
         [8'h20:8'h3F]: begin
            dec_type     = aucd_pkg::OP_SAVE_R19R20_X;
            dec_reg_wide = 6'd19;
            dec_opnd     = {20'd0, byte_a[4:0], 3'd0};
         end
         [8'h40:8'h7F]: begin
            dec_type     = aucd_pkg::OP_SAVE_FPLR;
            dec_reg_wide = 6'd29;
            dec_opnd     = {19'd0, byte_a[5:0], 3'd0};
         end
         [8'h80:8'hBF]: begin
            dec_type     = aucd_pkg::OP_SAVE_FPLR_X;
            dec_reg_wide = 6'd29;
            dec_opnd     = {18'd0, ({1'b0, byte_a[5:0]} + 7'd1), 3'd0};
         end
         [8'hC0:8'hC7]: begin
            dec_type = aucd_pkg::OP_ALLOC_M;
            dec_opnd = {13'd0, byte_a[2:0], byte_b, 4'd0};
         end
         [8'hC8:8'hCB]: begin
            dec_type     = aucd_pkg::OP_SAVE_REGP;
            dec_reg_wide = 6'd19 + {2'b00, byte_a[1:0], byte_b[7:6]};
            dec_opnd     = off6;
         end
         [8'hCC:8'hCF]: begin
            dec_type     = aucd_pkg::OP_SAVE_REGP_X;
            dec_reg_wide = 6'd19 + {2'b00, byte_a[1:0], byte_b[7:6]};
            dec_opnd     = off6p;
         end
         [8'hD0:8'hD3]: begin
            dec_type     = aucd_pkg::OP_SAVE_REG;
            dec_reg_wide = 6'd19 + {2'b00, byte_a[1:0], byte_b[7:6]};
            dec_opnd     = off6;
         end
         [8'hD4:8'hD5]: begin
            dec_type     = aucd_pkg::OP_SAVE_REG_X;
            dec_reg_wide = 6'd19 + {2'b00, byte_a[0], byte_b[7:5]};
            dec_opnd     = off5p;
         end
         [8'hD6:8'hD7]: begin
            // register pairs step by two
            dec_type     = aucd_pkg::OP_SAVE_LRPAIR;
            dec_reg_wide = 6'd19 + {2'b00, byte_a[0], byte_b[7:6], 1'b0};
            dec_opnd     = off6;
         end
         [8'hD8:8'hD9]: begin
            dec_type     = aucd_pkg::OP_SAVE_FREGP;
            dec_reg_wide = 6'd8 + {3'b000, byte_a[0], byte_b[7:6]};
            dec_opnd     = off6;
         end
         [8'hDA:8'hDB]: begin
            dec_type     = aucd_pkg::OP_SAVE_FREGP_X;
            dec_reg_wide = 6'd8 + {3'b000, byte_a[0], byte_b[7:6]};
            dec_opnd     = off6p;
         end
         [8'hDC:8'hDD]: begin
            dec_type     = aucd_pkg::OP_SAVE_FREG;
            dec_reg_wide = 6'd8 + {3'b000, byte_a[0], byte_b[7:6]};
            dec_opnd     = off6;
         end
         8'hDE: begin
            dec_type     = aucd_pkg::OP_SAVE_FREG_X;
            dec_reg_wide = 6'd8 + {3'b000, byte_b[7:5]};
            dec_opnd     = off5p;
         end
         aucd_pkg::CodeAllocL: begin
            dec_type = aucd_pkg::OP_ALLOC_L;
            dec_opnd = {byte_b, byte_c, byte_d, 4'd0};
         end
         aucd_pkg::CodeSetFp: begin
            dec_type     = aucd_pkg::OP_SET_FP;
            dec_reg_wide = 6'd29;
         end
         aucd_pkg::CodeAddFp: begin
            dec_type     = aucd_pkg::OP_ADD_FP;
            dec_reg_wide = 6'd29;
            dec_opnd     = {17'd0, byte_b, 3'd0};
         end
         aucd_pkg::CodeEnd: begin
            dec_type = aucd_pkg::OP_END;
         end
         aucd_pkg::CodeEndC: begin
            dec_type = aucd_pkg::OP_END_C;
         end
         aucd_pkg::CodeSaveNext: begin
            dec_type = aucd_pkg::OP_SAVE_NEXT;
         end
         aucd_pkg::CodePacSignLr: begin
            dec_type     = aucd_pkg::OP_PAC_SIGN_LR;
            dec_reg_wide = 6'd30;
         end
         default: begin
            dec_type = aucd_pkg::OP_NOP;
         end
      endcase
   end

   // Saturate out-of-range register encodings at x30.
   assign dec_reg  = (dec_reg_wide > 6'd30) ? 5'd30 : dec_reg_wide[4:0];
   assign end_seen = (dec_type == aucd_pkg::OP_END) || (dec_type == aucd_pkg::OP_END_C);
   assign emit     = !skip_ff && (complete || s1_data_ff.region_last);

   always_comb begin
      pos_in  = pos_ff;
      cnt_in  = cnt_ff;
      skip_in = skip_ff;
      rsp_data_in = rsp_data_ff;
      if (advance) begin
         if (!skip_ff) begin
            if (complete) begin
               pos_in = 3'd0;
               if (cnt_ff < aucd_pkg::MaxRegionOps) begin
                  cnt_in = cnt_ff + 10'd1;
               end
               if (end_seen) begin
                  skip_in = 1'b1;
               end
               rsp_data_in.op_type      = dec_type;
               rsp_data_in.reg_number   = dec_reg;
               rsp_data_in.byte_operand = dec_opnd;
               rsp_data_in.op_index     = cnt_ff;
               rsp_data_in.is_truncated = 1'b0;
            end else begin
               pos_in = pos_plus;
               // region ended inside a code
               rsp_data_in.op_type      = 5'd0;
               rsp_data_in.reg_number   = 5'd0;
               rsp_data_in.byte_operand = 28'd0;
               rsp_data_in.op_index     = 10'd0;
               rsp_data_in.is_truncated = 1'b1;
            end
         end
         if (s1_data_ff.region_last) begin
            pos_in  = 3'd0;
            cnt_in  = 10'd0;
            skip_in = 1'b0;
         end
      end
   end

   assign s1_valid_in  = req_take || (s1_valid_ff && !advance);
   assign rsp_valid_in = (advance && emit) || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= 3'd0;
         cnt_ff       <= 10'd0;
         skip_ff      <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         cnt_ff       <= cnt_in;
         skip_ff      <= skip_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_data_ff <= req_data;
      end
      if (advance && emit) begin
         rsp_data_ff <= rsp_data_in;
      end
      // keep only the first four bytes of a code
      if (advance && !skip_ff && (pos_ff < 3'd4)) begin
         gath_ff[pos_ff[1:0]] <= cb;
      end
   end

   `AUCD_ASSERT_IMP(a_stall_only_when_blocked, clock, reset, req_stall,
                    s1_valid_ff && rsp_valid_ff && rsp_stall)
   `AUCD_ASSERT_NEXT(a_region_end_clears, clock, reset, advance && s1_data_ff.region_last,
                     pos_ff == 3'd0 && cnt_ff == 10'd0 && !skip_ff)
   `AUCD_ASSERT_NEXT(a_end_sets_skip, clock, reset,
                     advance && emit && complete && end_seen && !s1_data_ff.region_last,
                     skip_ff)
   `AUCD_ASSERT_IMP(a_fifth_byte_completes, clock, reset,
                    advance && !skip_ff && pos_ff == 3'd4, complete && emit)

endmodule

// ----- tb/arm64_unwind_code_decoder_unit_tb.sv -----
// Self-checking bench for the unwind code decoder: byte stream in, decoded operations out.
// Needs aucd_pkg and arm64_unwind_code_decoder_unit; an in-bench decoder predicts each result.
`timescale 1ns / 100ps

module arm64_unwind_code_decoder_unit_tb;

   localparam int StallLimit = 1000;
   localparam int DirectedLen = 23;
   localparam int RandomBytes = 150;
   localparam int LongRegionOps = 1025;

   // first bytes that only set a length and decode as nop
   localparam logic [7:0] CodeSpareE7 = 8'hE7;
   localparam logic [7:0] CodeSpareF8 = 8'hF8;
   localparam logic [7:0] CodeSpareF9 = 8'hF9;
   localparam logic [7:0] CodeSpareFA = 8'hFA;
   localparam logic [7:0] CodeSpareFB = 8'hFB;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   aucd_pkg::req_beat_type req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   aucd_pkg::rsp_beat_type rsp_data;

   aucd_pkg::req_beat_type pending_beats[$];
   aucd_pkg::rsp_beat_type expected_ops[$];
   int                     drain_points[$];
   int                     beats_taken = 0;
   int                     fail_count = 0;

   // decoder state mirrored by the bench
   logic [2:0] frag_pos = '0;
   logic [7:0] frag_bytes[4] = '{default: 8'h00};
   logic [9:0] region_ops = '0;
   logic       skipping = 1'b0;

   arm64_unwind_code_decoder_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [2:0] code_len(logic [7:0] first);
      if (first <= 8'hBF) return 3'd1;
      if (first <= 8'hDF) return 3'd2;
      case (first)
         aucd_pkg::CodeAllocL: return 3'd4;
         aucd_pkg::CodeAddFp:  return 3'd2;
         CodeSpareE7:          return 3'd3;
         CodeSpareF8:          return 3'd2;
         CodeSpareF9:          return 3'd3;
         CodeSpareFA:          return 3'd4;
         CodeSpareFB:          return 3'd5;
         default:              return 3'd1;
      endcase
   endfunction

   function automatic aucd_pkg::rsp_beat_type decode_op(logic [7:0] a, logic [7:0] b,
                                                        logic [7:0] c, logic [7:0] d,
                                                        logic [9:0] index);
      aucd_pkg::op_kind_type  kind;
      int unsigned            reg_n;
      int unsigned            opnd;
      aucd_pkg::rsp_beat_type op;
      kind = aucd_pkg::OP_NOP;
      reg_n = 0;
      opnd = 0;
      if (a <= 8'h1F) begin
         kind = aucd_pkg::OP_ALLOC_S;
         opnd = a[4:0] * 16;
      end else if (a <= 8'h3F) begin
         kind = aucd_pkg::OP_SAVE_R19R20_X;
         reg_n = 19;
         opnd = a[4:0] * 8;
      end else if (a <= 8'h7F) begin
         kind = aucd_pkg::OP_SAVE_FPLR;
         reg_n = 29;
         opnd = a[5:0] * 8;
      end else if (a <= 8'hBF) begin
         kind = aucd_pkg::OP_SAVE_FPLR_X;
         reg_n = 29;
         opnd = (a[5:0] + 1) * 8;
      end else if (a <= 8'hC7) begin
         kind = aucd_pkg::OP_ALLOC_M;
         opnd = {a[2:0], b} * 16;
      end else if (a <= 8'hD3) begin
         kind = (a <= 8'hCB) ? aucd_pkg::OP_SAVE_REGP :
                (a <= 8'hCF) ? aucd_pkg::OP_SAVE_REGP_X : aucd_pkg::OP_SAVE_REG;
         reg_n = 19 + {a[1:0], b[7:6]};
         opnd = (kind == aucd_pkg::OP_SAVE_REGP_X) ? (b[5:0] + 1) * 8 : b[5:0] * 8;
      end else if (a <= 8'hD5) begin
         kind = aucd_pkg::OP_SAVE_REG_X;
         reg_n = 19 + {a[0], b[7:5]};
         opnd = (b[4:0] + 1) * 8;
      end else if (a <= 8'hD7) begin
         kind = aucd_pkg::OP_SAVE_LRPAIR;
         reg_n = 19 + 2 * {a[0], b[7:6]};
         opnd = b[5:0] * 8;
      end else if (a <= 8'hDD) begin
         kind = (a <= 8'hD9) ? aucd_pkg::OP_SAVE_FREGP :
                (a <= 8'hDB) ? aucd_pkg::OP_SAVE_FREGP_X : aucd_pkg::OP_SAVE_FREG;
         reg_n = 8 + {a[0], b[7:6]};
         opnd = (kind == aucd_pkg::OP_SAVE_FREGP_X) ? (b[5:0] + 1) * 8 : b[5:0] * 8;
      end else if (a == 8'hDE) begin
         kind = aucd_pkg::OP_SAVE_FREG_X;
         reg_n = 8 + b[7:5];
         opnd = (b[4:0] + 1) * 8;
      end else if (a == aucd_pkg::CodeAllocL) begin
         kind = aucd_pkg::OP_ALLOC_L;
         opnd = {b, c, d} * 16;
      end else if (a == aucd_pkg::CodeSetFp) begin
         kind = aucd_pkg::OP_SET_FP;
         reg_n = 29;
      end else if (a == aucd_pkg::CodeAddFp) begin
         kind = aucd_pkg::OP_ADD_FP;
         reg_n = 29;
         opnd = b * 8;
      end else if (a == aucd_pkg::CodeEnd) begin
         kind = aucd_pkg::OP_END;
      end else if (a == aucd_pkg::CodeEndC) begin
         kind = aucd_pkg::OP_END_C;
      end else if (a == aucd_pkg::CodeSaveNext) begin
         kind = aucd_pkg::OP_SAVE_NEXT;
      end else if (a == aucd_pkg::CodePacSignLr) begin
         kind = aucd_pkg::OP_PAC_SIGN_LR;
         reg_n = 30;
      end
      // out-of-range register encodings clamp to lr
      if (reg_n > 30) reg_n = 30;
      op.op_type = kind;
      op.reg_number = reg_n[4:0];
      op.byte_operand = opnd[27:0];
      op.op_index = index;
      op.is_truncated = 1'b0;
      return op;
   endfunction

   // Advance the mirrored decoder by one accepted byte; queue any result it yields.
   task automatic decode_code_byte(aucd_pkg::req_beat_type beat);
      aucd_pkg::rsp_beat_type op;
      if (skipping) begin
         if (beat.region_last) begin
            frag_pos = '0;
            region_ops = '0;
            skipping = 1'b0;
         end
         return;
      end
      if (frag_pos < 3'd4) frag_bytes[frag_pos[1:0]] = beat.code_byte;
      frag_pos = frag_pos + 3'd1;
      if (frag_pos >= code_len(frag_bytes[0])) begin
         op = decode_op(frag_bytes[0], frag_bytes[1], frag_bytes[2], frag_bytes[3],
                        region_ops);
         expected_ops.push_back(op);
         if (region_ops < aucd_pkg::MaxRegionOps) region_ops = region_ops + 10'd1;
         if (op.op_type == aucd_pkg::OP_END || op.op_type == aucd_pkg::OP_END_C)
            skipping = 1'b1;
         frag_pos = '0;
      end else if (beat.region_last) begin
         op = '0;
         op.is_truncated = 1'b1;
         expected_ops.push_back(op);
      end
      if (beat.region_last) begin
         frag_pos = '0;
         region_ops = '0;
         skipping = 1'b0;
      end
   endtask

   // random wait, with occasional runs of back-to-back beats
   function automatic int draw_wait(inout int quiet_run);
      if (quiet_run > 0) begin
         quiet_run--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         quiet_run = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 10);
   endfunction

   task automatic push_beat(logic [7:0] code_byte, bit last);
      aucd_pkg::req_beat_type beat;
      beat.code_byte = code_byte;
      beat.region_last = last;
      pending_beats.push_back(beat);
   endtask

   // whole code with random operand bytes; last marks its final byte
   task automatic push_code(logic [7:0] first, bit last);
      int len;
      len = code_len(first);
      push_beat(first, last && len == 1);
      for (int i = 1; i < len; i++)
         push_beat(8'($urandom_range(0, 255)), last && i == len - 1);
   endtask

   function automatic logic [7:0] pick_multi_byte_first();
      case ($urandom_range(0, 7))
         0:       return 8'($urandom_range(8'hC0, 8'hDF));
         1:       return aucd_pkg::CodeAllocL;
         2:       return aucd_pkg::CodeAddFp;
         3:       return CodeSpareE7;
         4:       return CodeSpareF8;
         5:       return CodeSpareF9;
         6:       return CodeSpareFA;
         default: return CodeSpareFB;
      endcase
   endfunction

   task automatic push_random_region();
      int          n_codes;
      int          ending;
      int          k;
      logic [7:0]  first;
      n_codes = $urandom_range(1, 12);
      ending = $urandom_range(0, 5);
      for (int i = 0; i < n_codes; i++) begin
         first = 8'($urandom_range(0, 255));
         // keep end codes from cutting most regions short
         if ((first == aucd_pkg::CodeEnd || first == aucd_pkg::CodeEndC) &&
             $urandom_range(0, 3) != 0)
            first = 8'($urandom_range(0, 8'hDF));
         push_code(first, ending < 4 && i == n_codes - 1);
      end
      if (ending == 4) begin
         first = pick_multi_byte_first();
         k = $urandom_range(0, code_len(first) - 2);
         push_beat(first, k == 0);
         for (int i = 1; i <= k; i++) push_beat(8'($urandom_range(0, 255)), i == k);
      end else if (ending == 5) begin
         push_beat(8'($urandom_range(0, 255)), 1'b1);
      end
   endtask

   task automatic push_long_region();
      logic [7:0] first;
      for (int i = 0; i < LongRegionOps; i++) begin
         do first = 8'($urandom_range(0, 255));
         while (code_len(first) != 1 || first == aucd_pkg::CodeEnd ||
                first == aucd_pkg::CodeEndC);
         push_beat(first, i == LongRegionOps - 1);
      end
   endtask

   // driver: present queued beats, predict on each accepted one
   always @(posedge clock) begin : driver
      int                     send_wait;
      int                     send_quiet;
      int                     next_item;
      logic                   next_valid;
      aucd_pkg::req_beat_type next_data;
      if (reset) begin
         send_wait = 0;
         send_quiet = 0;
         next_item = 0;
         req_valid <= 1'b0;
         req_data <= '0;
      end else begin
         next_valid = req_valid;
         next_data = req_data;
         if (req_valid && !req_stall) begin
            decode_code_byte(req_data);
            beats_taken++;
            next_valid = 1'b0;
         end
         if (!next_valid && next_item < pending_beats.size()) begin
            if (drain_points.size() != 0 && drain_points[0] == next_item &&
                expected_ops.size() == 0)
               drain_points.pop_front();
            if (send_wait > 0) begin
               send_wait--;
            end else if (drain_points.size() == 0 || drain_points[0] != next_item) begin
               next_valid = 1'b1;
               next_data = pending_beats[next_item];
               next_item++;
               send_wait = draw_wait(send_quiet);
            end
         end
         req_valid <= next_valid;
         req_data <= next_data;
      end
   end

   // monitor: stall at random, check each accepted result beat
   always @(posedge clock) begin : monitor
      int                     hold_left;
      int                     hold_quiet;
      aucd_pkg::rsp_beat_type want;
      if (reset) begin
         hold_left = 0;
         hold_quiet = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_ops.size() == 0) begin
               $error("result beat with nothing expected: %p", rsp_data);
               fail_count++;
            end else begin
               want = expected_ops.pop_front();
               if (rsp_data.op_type !== want.op_type) begin
                  $error("op_type: expected %0d, got %0d", want.op_type, rsp_data.op_type);
                  fail_count++;
               end
               if (rsp_data.reg_number !== want.reg_number) begin
                  $error("reg_number: expected %0d, got %0d",
                         want.reg_number, rsp_data.reg_number);
                  fail_count++;
               end
               if (rsp_data.byte_operand !== want.byte_operand) begin
                  $error("byte_operand: expected %0d, got %0d",
                         want.byte_operand, rsp_data.byte_operand);
                  fail_count++;
               end
               if (rsp_data.op_index !== want.op_index) begin
                  $error("op_index: expected %0d, got %0d", want.op_index, rsp_data.op_index);
                  fail_count++;
               end
               if (rsp_data.is_truncated !== want.is_truncated) begin
                  $error("is_truncated: expected %0d, got %0d",
                         want.is_truncated, rsp_data.is_truncated);
                  fail_count++;
               end
            end
            hold_left = draw_wait(hold_quiet);
         end
         rsp_stall <= (hold_left > 0);
         if (hold_left > 0) hold_left--;
      end
   end

   always @(posedge clock) begin : watchdog
      int idle_cycles;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else if (idle_cycles >= StallLimit) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles++;
      end
   end

   initial begin
      // directed: range extremes, clamped register, long codes, unknown code,
      // end_c with skipped bytes, then a code cut off by the region end
      push_beat(8'h00, 1'b0);
      push_beat(8'hBF, 1'b0);
      push_beat(8'hC7, 1'b0);
      push_beat(8'hFF, 1'b0);
      push_beat(8'hD3, 1'b0);
      push_beat(8'hFF, 1'b0);
      push_beat(aucd_pkg::CodeAllocL, 1'b0);
      push_beat(8'hFF, 1'b0);
      push_beat(8'hFF, 1'b0);
      push_beat(8'hFF, 1'b0);
      push_beat(aucd_pkg::CodeSetFp, 1'b0);
      push_beat(aucd_pkg::CodeAddFp, 1'b0);
      push_beat(8'hFF, 1'b0);
      push_beat(aucd_pkg::CodeSaveNext, 1'b0);
      push_beat(aucd_pkg::CodePacSignLr, 1'b0);
      push_beat(8'hDF, 1'b0);
      push_beat(8'h00, 1'b0);
      push_beat(aucd_pkg::CodeEndC, 1'b0);
      push_beat(8'h33, 1'b0);
      push_beat(8'h44, 1'b1);
      push_beat(aucd_pkg::CodeAllocL, 1'b0);
      push_beat(8'h12, 1'b1);
      push_beat(aucd_pkg::CodeEnd, 1'b1);

      // hold the sender until the directed results have all come back
      drain_points.push_back(pending_beats.size());
      push_long_region();
      drain_points.push_back(pending_beats.size());
      while (pending_beats.size() < DirectedLen + LongRegionOps + RandomBytes)
         push_random_region();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (beats_taken < pending_beats.size()) @(posedge clock);
      while (expected_ops.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ----- arm64_unwind_code_decoder_unit.f -----
+incdir+rtl/core
rtl/core/aucd_pkg.sv
rtl/core/arm64_unwind_code_decoder_unit.sv
tb/arm64_unwind_code_decoder_unit_tb.sv
